@@ design/ewse_pkg.sv @@
// Shared types, constants and the build-time steering table for the wheel speed estimator.
`default_nettype none
package ewse_pkg;

   localparam int unsigned DEF_MAX_ANGLE_MILLIRAD = 524;
   localparam int unsigned DEF_STEER_SPAN         = 45;

   localparam int POS_W      = 7;
   localparam int SPEED_IN_W = 16;
   localparam int SPEED_W    = 25;
   localparam int RAD_W      = 16;
   localparam int TOL_W      = 24;
   localparam int U_W        = 20;   // 3s + 5.0, 3s + 5c and 5c
   localparam int W_W        = 21;   // 3t + 5.0
   localparam int NUM_W      = 44;   // divider numerators
   localparam int Q5_W       = 28;   // rounded product over 2^16, before the divide by five
   localparam int PROD_W     = 56;
   localparam int SUM_W      = 26;

   localparam logic [POS_W-1:0] CENTRE_POS = 7'd50;
   localparam logic [TOL_W-1:0] TOL_RESET  = 24'd256;

   localparam int unsigned ROUND_HALF   = 163840;        // half of 5 * 2^16
   localparam int unsigned Q16_SHIFT    = 16;
   localparam logic [27:0] DIV5_MUL     = 28'hCCCCCCD;   // ceil(2^30 / 5)
   localparam int unsigned DIV5_SHIFT   = 30;
   localparam int unsigned OUTER_SCALE  = 83886080;      // 256 * 5 * 2^16
   localparam int unsigned QUEUE_DEPTH  = 2;
   localparam int unsigned DIV_LATENCY  = SPEED_W + 2;
   localparam int unsigned BACK_STAGES  = 5;

   localparam logic [63:0] ONE30       = 64'd1 << 30;
   localparam logic [63:0] FIVE_Q16    = 64'd327680;
   localparam logic [63:0] RAD_NUM     = 64'd41943040;   // 2.5 in Q8.8 over a Q2.16 ratio
   localparam logic [63:0] RAD_MAX     = 64'd65535;
   localparam logic [63:0] TAN_MAX     = 64'h3FFFF;
   localparam logic [63:0] RAD_OUTER   = 64'd384;        // 1.5 in Q8.8

   typedef struct packed {
      logic [POS_W-1:0]      steering_position;
      logic [SPEED_IN_W-1:0] speed_front_left;
      logic [SPEED_IN_W-1:0] speed_front_right;
   } req_type;

   typedef struct packed {
      logic [SPEED_W-1:0] expect_front_left;
      logic [SPEED_W-1:0] expect_front_right;
      logic [SPEED_W-1:0] expect_rear_left;
      logic [SPEED_W-1:0] expect_rear_right;
      logic [RAD_W-1:0]   radius_inner_front;
      logic [RAD_W-1:0]   radius_outer_front;
      logic [RAD_W-1:0]   radius_inner_rear;
      logic [RAD_W-1:0]   radius_outer_rear;
      logic               outer_slipping;
      logic               turn_high_side;
   } rsp_type;

   typedef struct packed {
      logic [U_W-1:0]   u;     // 3s + 5.0
      logic [U_W-1:0]   v;     // 3s + 5c
      logic [W_W-1:0]   w;     // 3t + 5.0
      logic [U_W-1:0]   c5;    // 5c
      logic [RAD_W-1:0] rad_if;
      logic [RAD_W-1:0] rad_of;
      logic [RAD_W-1:0] rad_ir;
      logic [RAD_W-1:0] rad_or;
   } rom_type;

   typedef struct packed {
      logic                  high;
      logic [SPEED_IN_W-1:0] inner;
      logic [SPEED_IN_W-1:0] outer;
      rom_type               rom;
   } item_type;

   typedef struct packed {
      logic                  high;
      logic                  slip;
      logic [SPEED_W-1:0]    expect_outer;
      logic [SPEED_IN_W-1:0] inner;
      logic [RAD_W-1:0]      rad_if;
      logic [RAD_W-1:0]      rad_of;
      logic [RAD_W-1:0]      rad_ir;
      logic [RAD_W-1:0]      rad_or;
   } side_type;

   // Shift-subtract division for table generation; a zero divisor gives all ones.
   function automatic logic [63:0] cdiv(input logic [63:0] n, input logic [63:0] d);
      logic [63:0] q;
      logic [64:0] r;
      int          i;
      q = '0;
      r = '0;
      for (i = 63; i >= 0; i--) begin
         r = {r[63:0], n[i]};
         if (r >= {1'b0, d}) begin
            r    = r - {1'b0, d};
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic logic [63:0] cdiv_round(input logic [63:0] n, input logic [63:0] d);
      return cdiv(n + (d >> 1), d);
   endfunction

   // Truncating Taylor series in Q.30, sine when odd is set
   function automatic logic [63:0] taylor30(input logic [63:0] x, input logic odd);
      logic [63:0] term;
      logic [63:0] n;
      longint      sum;
      int          i;
      term = odd ? x : ONE30;
      sum  = longint'(term);
      n    = odd ? 64'd1 : 64'd0;
      for (i = 1; i <= 14; i++) begin
         term = (term * x) >> 30;
         term = (term * x) >> 30;
         term = cdiv(term, (n + 64'd1) * (n + 64'd2));
         n    = n + 64'd2;
         if (i[0])
            sum = sum - longint'(term);
         else
            sum = sum + longint'(term);
      end
      return (sum < 0) ? 64'd0 : 64'(sum);
   endfunction

   function automatic rom_type rom_entry(input int unsigned k, input int unsigned max_mrad,
                                         input int unsigned span);
      rom_type     e;
      logic [63:0] x;
      logic [63:0] s30;
      logic [63:0] c30;
      logic [63:0] s;
      logic [63:0] c;
      logic [63:0] t;
      logic [63:0] r0;
      logic [63:0] r2;
      x   = cdiv_round(64'(max_mrad) * 64'(k) * ONE30, 64'd1000 * 64'(span));
      s30 = taylor30(x, 1'b1);
      c30 = taylor30(x, 1'b0);
      s   = (s30 + 64'd8192) >> 14;
      c   = (c30 + 64'd8192) >> 14;
      t   = cdiv_round(s30 << 16, c30);
      if (t > TAN_MAX)
         t = TAN_MAX;
      e.u  = U_W'(64'd3 * s + FIVE_Q16);
      e.v  = U_W'(64'd3 * s + 64'd5 * c);
      e.w  = W_W'(64'd3 * t + FIVE_Q16);
      e.c5 = U_W'(64'd5 * c);
      if (k == 0) begin
         e.rad_if = '0;
         e.rad_of = '0;
         e.rad_ir = '0;
         e.rad_or = '0;
      end else begin
         r0 = cdiv_round(RAD_NUM, s);
         r2 = cdiv_round(RAD_NUM, t);
         if (r0 > RAD_MAX)
            r0 = RAD_MAX;
         if (r2 > RAD_MAX)
            r2 = RAD_MAX;
         e.rad_if = RAD_W'(r0);
         e.rad_ir = RAD_W'(r2);
         e.rad_of = RAD_W'((r0 + RAD_OUTER > RAD_MAX) ? RAD_MAX : r0 + RAD_OUTER);
         e.rad_or = RAD_W'((r2 + RAD_OUTER > RAD_MAX) ? RAD_MAX : r2 + RAD_OUTER);
      end
      return e;
   endfunction

endpackage
`default_nettype wire

@@ design/ewse_front.sv @@
// Front end: steering side and offset, table look-up, inner/outer wheel selection.
`default_nettype none
module ewse_front
   import ewse_pkg::*;
#(
   parameter int unsigned MAX_ANGLE_MILLIRAD = DEF_MAX_ANGLE_MILLIRAD,
   parameter int unsigned STEER_SPAN         = DEF_STEER_SPAN
) (
   input  req_type  req_data,
   output item_type item
);

   localparam int K_BITS = (STEER_SPAN > 0) ? $clog2(STEER_SPAN + 1) : 1;

   rom_type          rom_tbl [STEER_SPAN + 1];
   logic             high;
   logic [POS_W-1:0] k_raw;
   logic [K_BITS-1:0] k;

   for (genvar g = 0; g <= STEER_SPAN; g++) begin : g_rom
      localparam rom_type ENTRY = rom_entry(g, MAX_ANGLE_MILLIRAD, STEER_SPAN);
      assign rom_tbl[g] = ENTRY;
   end

   assign high  = req_data.steering_position >= CENTRE_POS;
   assign k_raw = high ? req_data.steering_position - CENTRE_POS
                       : CENTRE_POS - req_data.steering_position;
   // offsets past full lock clamp to full lock
   assign k     = (k_raw > POS_W'(STEER_SPAN)) ? K_BITS'(STEER_SPAN) : K_BITS'(k_raw);

   assign item.high  = high;
   assign item.outer = high ? req_data.speed_front_left : req_data.speed_front_right;
   assign item.inner = high ? req_data.speed_front_right : req_data.speed_front_left;
   assign item.rom   = rom_tbl[k];

endmodule
`default_nettype wire

@@ design/ewse_queue.sv @@
// Short register queue between the front end and the arithmetic back end.
`default_nettype none
module ewse_queue
   import ewse_pkg::*;
#(
   parameter int WIDTH = $bits(item_type),
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push)
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      cnt_in = cnt_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push)
         mem_ff[wr_ptr_ff] <= push_data;
   end

   assign pop_data = mem_ff[rd_ptr_ff];
   assign full     = cnt_ff == CNT_W'(DEPTH);
   assign empty    = cnt_ff == '0;

endmodule
`default_nettype wire

@@ design/ewse_div.sv @@
// Pipelined restoring divider, rounding half up, one quotient bit per stage, saturating.
`default_nettype none
module ewse_div
   import ewse_pkg::*;
#(
   parameter int NUM_BITS = NUM_W,
   parameter int DEN_BITS = U_W,
   parameter int QUO_BITS = SPEED_W
) (
   input  logic                clock,
   input  logic                enable,
   input  logic [NUM_BITS-1:0] num,
   input  logic [DEN_BITS-1:0] den,
   output logic [QUO_BITS-1:0] quot
);

   localparam int RND_BITS = NUM_BITS + 1;
   localparam int TOP_BITS = RND_BITS - QUO_BITS;
   localparam int CMP_BITS = (TOP_BITS > DEN_BITS) ? TOP_BITS : DEN_BITS;

   logic [RND_BITS-1:0] rnd_ff, rnd_in;
   logic [DEN_BITS-1:0] den0_ff;
   logic [CMP_BITS-1:0] top;
   logic                sat0_in;

   logic [DEN_BITS-1:0] rem_ff [QUO_BITS + 1];
   logic [QUO_BITS-1:0] low_ff [QUO_BITS + 1];
   logic [QUO_BITS-1:0] quo_ff [QUO_BITS + 1];
   logic [DEN_BITS-1:0] den_ff [QUO_BITS + 1];
   logic                sat_ff [QUO_BITS + 1];

   assign rnd_in = {1'b0, num} + RND_BITS'(den >> 1);

   always_ff @(posedge clock) begin
      if (enable) begin
         rnd_ff  <= rnd_in;
         den0_ff <= den;
      end
   end

   // quotient would not fit when the leading part already reaches the divisor
   assign top     = CMP_BITS'(rnd_ff >> QUO_BITS);
   assign sat0_in = top >= CMP_BITS'(den0_ff);

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff[0] <= DEN_BITS'(top);
         low_ff[0] <= rnd_ff[QUO_BITS-1:0];
         quo_ff[0] <= '0;
         den_ff[0] <= den0_ff;
         sat_ff[0] <= sat0_in;
      end
   end

   for (genvar j = 1; j <= QUO_BITS; j++) begin : g_step
      logic [DEN_BITS:0]   trial;
      logic [DEN_BITS:0]   diff;
      logic                ge;
      logic [DEN_BITS-1:0] rem_in;
      logic [QUO_BITS-1:0] quo_in;

      assign trial  = {rem_ff[j-1], low_ff[j-1][QUO_BITS-1]};
      assign diff   = trial - {1'b0, den_ff[j-1]};
      assign ge     = trial >= {1'b0, den_ff[j-1]};
      assign rem_in = ge ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
      assign quo_in = (quo_ff[j-1] << 1) | QUO_BITS'(ge);

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[j] <= rem_in;
            low_ff[j] <= low_ff[j-1] << 1;
            quo_ff[j] <= quo_in;
            den_ff[j] <= den_ff[j-1];
            sat_ff[j] <= sat_ff[j-1];
         end
      end
   end

   assign quot = sat_ff[QUO_BITS] ? '1 : quo_ff[QUO_BITS];

endmodule
`default_nettype wire

@@ design/ewse_back.sv @@
// Back end: slip test, expected speeds through three dividers, output register.
`default_nettype none
module ewse_back
   import ewse_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [TOL_W-1:0] slip_tolerance,
   input  logic             q_empty,
   input  item_type         q_item,
   output logic             q_pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data
);

   localparam int STAGES = BACK_STAGES + DIV_LATENCY;

   logic              advance;
   logic [STAGES-1:0] vld_ff, vld_in;
   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff, rsp_data_in;

   item_type          it1_ff, it2_ff, it3_ff, it4_ff;
   logic [NUM_W-1:0]  p1_ff, p1_in;
   logic [Q5_W-1:0]   q2_ff, q2_in;
   logic [PROD_W-1:0] prod3_ff, prod3_in;
   logic [SPEED_W-1:0] up4;
   logic [23:0]       outer256;
   logic              slip4_ff, slip4_in;
   logic [SPEED_W-1:0] o4_ff, o4_in;
   logic [NUM_W-1:0]  inum4_ff, inum4_in;

   logic [NUM_W-1:0]  nv5_ff, nv5_in;
   logic [NUM_W-1:0]  nc5_ff, nc5_in;
   logic [NUM_W-1:0]  inum5_ff;
   logic [U_W-1:0]    u5_ff;
   logic [W_W-1:0]    w5_ff;
   side_type          side5_ff, side5_in;
   side_type          side_ff [DIV_LATENCY];

   logic [SPEED_W-1:0] q_inner, q_rear_outer, q_rear_inner, expect_inner;
   side_type           side_out;

   // whole pipe holds while a finished result waits
   assign advance = !rsp_valid_ff || !rsp_stall;
   assign q_pop   = advance && !q_empty;
   assign vld_in  = {vld_ff[STAGES-2:0], !q_empty};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         vld_ff       <= vld_in;
         rsp_valid_ff <= vld_ff[STAGES-1];
      end
   end

   // inner * 256 * U, then round over 5.0 as (x >> 16) / 5 by reciprocal
   assign p1_in    = NUM_W'({q_item.inner, 8'b0}) * NUM_W'(q_item.rom.u);
   assign q2_in    = Q5_W'((p1_ff + NUM_W'(ROUND_HALF)) >> Q16_SHIFT);
   assign prod3_in = PROD_W'(q2_ff) * PROD_W'(DIV5_MUL);

   assign up4      = SPEED_W'(prod3_ff >> DIV5_SHIFT);
   assign outer256 = {it3_ff.outer, 8'b0};
   assign slip4_in = (SUM_W'(outer256) + SUM_W'(slip_tolerance)) < SUM_W'(up4);
   assign o4_in    = slip4_in ? up4 : SPEED_W'(outer256);
   assign inum4_in = NUM_W'(it3_ff.outer) * NUM_W'(OUTER_SCALE);

   assign nv5_in = NUM_W'(o4_ff) * NUM_W'(it4_ff.rom.v);
   assign nc5_in = NUM_W'(o4_ff) * NUM_W'(it4_ff.rom.c5);

   always_comb begin
      side5_in.high         = it4_ff.high;
      side5_in.slip         = slip4_ff;
      side5_in.expect_outer = o4_ff;
      side5_in.inner        = it4_ff.inner;
      side5_in.rad_if       = it4_ff.rom.rad_if;
      side5_in.rad_of       = it4_ff.rom.rad_of;
      side5_in.rad_ir       = it4_ff.rom.rad_ir;
      side5_in.rad_or       = it4_ff.rom.rad_or;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         it1_ff   <= q_item;
         p1_ff    <= p1_in;
         it2_ff   <= it1_ff;
         q2_ff    <= q2_in;
         it3_ff   <= it2_ff;
         prod3_ff <= prod3_in;
         it4_ff   <= it3_ff;
         slip4_ff <= slip4_in;
         o4_ff    <= o4_in;
         inum4_ff <= inum4_in;
         nv5_ff   <= nv5_in;
         nc5_ff   <= nc5_in;
         inum5_ff <= inum4_ff;
         u5_ff    <= it4_ff.rom.u;
         w5_ff    <= it4_ff.rom.w;
         side5_ff <= side5_in;
         side_ff[0] <= side5_ff;
      end
   end

   for (genvar j = 1; j < DIV_LATENCY; j++) begin : g_side
      always_ff @(posedge clock) begin
         if (advance)
            side_ff[j] <= side_ff[j-1];
      end
   end

   ewse_div #(.NUM_BITS(NUM_W), .DEN_BITS(U_W), .QUO_BITS(SPEED_W)) u_div_inner (
      .clock  (clock),
      .enable (advance),
      .num    (inum5_ff),
      .den    (u5_ff),
      .quot   (q_inner)
   );

   ewse_div #(.NUM_BITS(NUM_W), .DEN_BITS(U_W), .QUO_BITS(SPEED_W)) u_div_rear_outer (
      .clock  (clock),
      .enable (advance),
      .num    (nv5_ff),
      .den    (u5_ff),
      .quot   (q_rear_outer)
   );

   ewse_div #(.NUM_BITS(NUM_W), .DEN_BITS(W_W), .QUO_BITS(SPEED_W)) u_div_rear_inner (
      .clock  (clock),
      .enable (advance),
      .num    (nc5_ff),
      .den    (w5_ff),
      .quot   (q_rear_inner)
   );

   assign side_out     = side_ff[DIV_LATENCY-1];
   // a slipping outer wheel was re-derived, so the inner wheel is taken as measured
   assign expect_inner = side_out.slip ? SPEED_W'({side_out.inner, 8'b0}) : q_inner;

   always_comb begin
      rsp_data_in.expect_front_left  = side_out.high ? side_out.expect_outer : expect_inner;
      rsp_data_in.expect_front_right = side_out.high ? expect_inner : side_out.expect_outer;
      rsp_data_in.expect_rear_left   = side_out.high ? q_rear_outer : q_rear_inner;
      rsp_data_in.expect_rear_right  = side_out.high ? q_rear_inner : q_rear_outer;
      rsp_data_in.radius_inner_front = side_out.rad_if;
      rsp_data_in.radius_outer_front = side_out.rad_of;
      rsp_data_in.radius_inner_rear  = side_out.rad_ir;
      rsp_data_in.radius_outer_rear  = side_out.rad_or;
      rsp_data_in.outer_slipping     = side_out.slip;
      rsp_data_in.turn_high_side     = side_out.high;
   end

   always_ff @(posedge clock) begin
      if (advance)
         rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

@@ design/expected_wheel_speed_estimator.sv @@
// Top level of the expected wheel speed estimator: front end, queue, back end, slip register.
// Takes one steering reading with the two front wheel speeds per transfer and returns the
// expected speeds of all four wheels (Q.8), the four turning radii (Q8.8, zero at centre),
// a slip flag for the outer front wheel and the steering side. One item is accepted per
// clock while req_stall is low; the depth of the pipeline from transfer to result is
// set mostly by the 25 quotient bits of the restoring dividers, one per stage. Angle
// ratios and radii come from a table built at elaboration from MAX_ANGLE_MILLIRAD and
// STEER_SPAN. slip_tolerance is written through the csr port, which is always ready, and
// should only change while no item is in flight.
`default_nettype none
module expected_wheel_speed_estimator
   import ewse_pkg::*;
#(
   parameter int unsigned MAX_ANGLE_MILLIRAD = DEF_MAX_ANGLE_MILLIRAD,
   parameter int unsigned STEER_SPAN         = DEF_STEER_SPAN
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [TOL_W-1:0] csr_data
);

   logic [TOL_W-1:0] slip_tol_ff, slip_tol_in;
   item_type         front_item;
   item_type         head_item;
   logic             q_full;
   logic             q_empty;
   logic             q_pop;
   logic             q_push;

   assign csr_ready   = 1'b1;
   assign slip_tol_in = csr_valid ? csr_data : slip_tol_ff;

   always_ff @(posedge clock) begin
      if (reset)
         slip_tol_ff <= TOL_RESET;
      else
         slip_tol_ff <= slip_tol_in;
   end

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   ewse_front #(
      .MAX_ANGLE_MILLIRAD (MAX_ANGLE_MILLIRAD),
      .STEER_SPAN         (STEER_SPAN)
   ) u_front (
      .req_data (req_data),
      .item     (front_item)
   );

   ewse_queue #(
      .WIDTH ($bits(item_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (front_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (head_item),
      .empty     (q_empty)
   );

   ewse_back u_back (
      .clock          (clock),
      .reset          (reset),
      .slip_tolerance (slip_tol_ff),
      .q_empty        (q_empty),
      .q_item         (head_item),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data)
   );

endmodule
`default_nettype wire
